// ----- hw/rtl/rre_pkg.sv -----
// Shared constants and types for the recursive level estimator.
package rre_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int EST_FRAC_BITS = 22;
	localparam int EST_BITS      = EST_FRAC_BITS + 2;
	localparam int COEFF_BITS    = 24;
	localparam int PROD_BITS     = EST_BITS + COEFF_BITS;
	// quotient = mag * 2^DIV_SHIFT / est
	localparam int DIV_SHIFT     = 2 * EST_FRAC_BITS - SAMPLE_BITS + 1;
	// mag * 2^SAT_SHIFT >= est  <=>  quotient does not fit EST_BITS
	localparam int SAT_SHIFT     = DIV_SHIFT - EST_BITS;
	localparam int CNT_BITS      = $clog2(EST_BITS);

	typedef logic [EST_BITS-1:0]          est_t;
	typedef logic [COEFF_BITS-1:0]        coeff_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [PROD_BITS-1:0]         prod_t;

	localparam est_t   EST_ONE     = est_t'(1) << EST_FRAC_BITS;
	localparam est_t   EST_MAX     = '1;
	localparam est_t   EST_MIN     = est_t'(1);
	localparam coeff_t COEFF_RESET = coeff_t'(1747);
	localparam prod_t  ROUND_HALF  = prod_t'(1) << (COEFF_BITS - 1);

	localparam logic CMD_PROCESS = 1'b0;
	localparam logic CMD_FLUSH   = 1'b1;

endpackage

// ----- hw/rtl/rre_if.sv -----
// Request and result channel interfaces of the level estimator.
interface rre_item_if;
	logic             valid;
	logic             ready;
	logic             command;
	rre_pkg::sample_t sample;

	modport source (output valid, output command, output sample, input ready);
	modport sink (input valid, input command, input sample, output ready);
endinterface

interface rre_result_if;
	logic          valid;
	logic          ready;
	rre_pkg::est_t rms_value;
	logic          quotient_saturated;

	modport source (output valid, output rms_value, output quotient_saturated, input ready);
	modport sink (input valid, input rms_value, input quotient_saturated, output ready);
endinterface

// ----- hw/rtl/recursive_rms_estimator.sv -----
// Recursive level estimator: |x|/estimate by restoring division, then smoothing update.
// A sample request is accepted in ST_IDLE, then come 24 divide steps on the subtractor (ST_DIV),
// 1 multiply (ST_MUL) and 1 update (ST_DONE); a saturated quotient skips the divide and a flush
// goes straight to the update. One request at a time. A finished result waits in the output
// register and the next request is taken meanwhile; the next update stalls until it is taken.
// Reset (arst_n low): estimate 1.0, coefficient 1747, no result pending.
module recursive_rms_estimator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 coeff_wr_en,
	input  rre_pkg::coeff_t      coeff_wr_data,
	rre_item_if.sink             item,
	rre_result_if.source         result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} state_t;

	state_t                         state_q;
	rre_pkg::est_t                  est_q;
	rre_pkg::coeff_t                coeff_q;
	rre_pkg::est_t                  rem_q;
	rre_pkg::est_t                  quo_q;
	logic [rre_pkg::CNT_BITS-1:0]   cnt_q;
	logic                           sat_q;
	logic                           flush_q;
	logic                           up_q;
	rre_pkg::prod_t                 prod_q;
	logic                           out_valid_q;
	rre_pkg::est_t                  out_rms_q;
	logic                           out_sat_q;

	logic [rre_pkg::SAMPLE_BITS-1:0] mag;
	rre_pkg::est_t                   num;
	logic                            sat_now;
	logic [rre_pkg::EST_BITS:0]      trial;
	logic [rre_pkg::EST_BITS:0]      diff;
	logic                            ge;
	rre_pkg::est_t                   delta_mag;
	rre_pkg::prod_t                  rnd;
	rre_pkg::est_t                   m;
	logic [rre_pkg::EST_BITS:0]      sum;
	rre_pkg::est_t                   est_next;
	logic                            out_free;

	always_comb begin
		mag = item.sample[rre_pkg::SAMPLE_BITS-1]
			? rre_pkg::SAMPLE_BITS'(~item.sample + 1'b1)
			: rre_pkg::SAMPLE_BITS'(item.sample);
		num = rre_pkg::EST_BITS'({mag, {rre_pkg::SAT_SHIFT{1'b0}}});
		sat_now = num >= est_q;

		trial = {rem_q, 1'b0};
		diff = trial - {1'b0, est_q};
		ge = !diff[rre_pkg::EST_BITS];

		delta_mag = (quo_q >= est_q) ? (quo_q - est_q) : (est_q - quo_q);

		rnd = prod_q + rre_pkg::ROUND_HALF;
		m = rnd[rre_pkg::PROD_BITS-1:rre_pkg::COEFF_BITS];
		sum = {1'b0, est_q} + {1'b0, m};
		if (flush_q) begin
			est_next = rre_pkg::EST_ONE;
		end else if (up_q) begin
			est_next = sum[rre_pkg::EST_BITS] ? rre_pkg::EST_MAX
				: sum[rre_pkg::EST_BITS-1:0];
		end else begin
			est_next = (m >= est_q) ? rre_pkg::EST_MIN : (est_q - m);
		end

		out_free = !out_valid_q || result.ready;
	end

	assign item.ready                = (state_q == ST_IDLE);
	assign result.valid              = out_valid_q;
	assign result.rms_value          = out_rms_q;
	assign result.quotient_saturated = out_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			est_q       <= rre_pkg::EST_ONE;
			coeff_q     <= rre_pkg::COEFF_RESET;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			sat_q       <= 1'b0;
			flush_q     <= 1'b0;
			up_q        <= 1'b0;
			rem_q       <= '0;
			quo_q       <= '0;
			prod_q      <= '0;
			out_rms_q   <= '0;
			out_sat_q   <= 1'b0;
		end else begin
			if (coeff_wr_en) begin
				coeff_q <= coeff_wr_data;
			end
			if (out_valid_q && result.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						flush_q <= (item.command == rre_pkg::CMD_FLUSH);
						sat_q   <= (item.command == rre_pkg::CMD_PROCESS) && sat_now;
						rem_q   <= num;
						quo_q   <= ((item.command == rre_pkg::CMD_PROCESS) && sat_now)
							? rre_pkg::EST_MAX : '0;
						cnt_q   <= rre_pkg::CNT_BITS'(rre_pkg::EST_BITS - 1);
						if (item.command == rre_pkg::CMD_FLUSH) begin
							state_q <= ST_DONE;
						end else if (sat_now) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q <= ge ? diff[rre_pkg::EST_BITS-1:0] : trial[rre_pkg::EST_BITS-1:0];
					quo_q <= {quo_q[rre_pkg::EST_BITS-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= rre_pkg::PROD_BITS'(delta_mag) * rre_pkg::PROD_BITS'(coeff_q);
					up_q    <= quo_q >= est_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						est_q       <= est_next;
						out_rms_q   <= est_next;
						out_sat_q   <= sat_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_est_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		est_q != '0)
		else $error("level estimate reached zero");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < est_q))
		else $error("divider remainder not below divisor");

	a_sat_quo: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && sat_q) |-> (quo_q == rre_pkg::EST_MAX))
		else $error("saturated quotient not clamped");

	a_flush_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && flush_q && out_free) |=>
		(out_rms_q == rre_pkg::EST_ONE && !out_sat_q && out_valid_q))
		else $error("flush did not return estimate to 1.0");

endmodule
